// File: src/indexed_sequence_store_unit_macros.svh
// Assertion macros shared by the indexed sequence store unit.
// Each macro checks a property on the rising edge of clk, disabled while rst_n is low.
`ifndef INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ISU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property failed");
// Next-cycle implication.
`define ISU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property failed");
`else
`define ISU_ASSERT_SAME(lbl, ante, cons)
`define ISU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/isu_pkg.sv
package isu_pkg;

  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int TOTAL_W  = 5;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // open a slot at the index and load the new value
    logic rem;  // close the slot at the index
  } cell_cmd_t;

endpackage

// File: src/isu_in_if.sv
interface isu_in_if;
  import isu_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [POS_W-1:0]           position;
  logic signed [VAL_W-1:0]    item_value;

  modport source (output valid, output req_type, output position, output item_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input item_value,
                  output ready);
endinterface

// File: src/isu_out_if.sv
interface isu_out_if;
  import isu_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VAL_W-1:0]    read_value;
  logic [TOTAL_W-1:0]         element_total;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, output read_value, output element_total, output status,
                  input ready);
  modport sink   (input valid, input read_value, input element_total, input status,
                  output ready);
endinterface

// File: src/isu_cell.sv
module isu_cell #(
  parameter int IDX_W = 4,
  parameter int DW    = 32,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  isu_pkg::cell_cmd_t cmd,
  input  logic [IDX_W-1:0]   idx,
  input  logic [DW-1:0]      new_val,
  input  logic [DW-1:0]      left_val,
  input  logic [DW-1:0]      right_val,
  output logic [DW-1:0]      data_q
);
  import isu_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DW-1:0] data_r;
  logic [DW-1:0] data_nxt;

  // On insert, the cell at the slot loads the new value and cells above the slot take their
  // left neighbor; on remove, cells at or above the slot take their right neighbor.
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (MY_IDX == idx) begin
        data_nxt = new_val;
      end else if (MY_IDX > idx) begin
        data_nxt = left_val;
      end
    end else if (cmd.rem && (MY_IDX >= idx)) begin
      data_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// File: src/indexed_sequence_store_unit.sv
// A request's result is registered and shown in the cycle after the request is taken.
// Throughput: one request per cycle unless the output register stalls; the chain of cells shifts in the same edge.
// The output register stalls the input only while a result waits with out_ready low.
// Reset (synchronous, rst_n low) empties the store and drops any pending result;
// cell contents are not cleared, since only positions below the count are read.
`include "indexed_sequence_store_unit_macros.svh"

module indexed_sequence_store_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  isu_in_if.sink     in_ch,
  isu_out_if.source  out_ch
);
  import isu_pkg::*;

  // Index width addresses one cell; count width can also hold CAPACITY itself.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Element count and the registered result.
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] read_value_r;
  logic [TOTAL_W-1:0]      total_r;
  logic [STATUS_W-1:0]     status_r;

  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    pos_past_end;
  logic [CMP_W-1:0]        pos_x;
  logic [CMP_W-1:0]        cnt_x;
  logic [IDX_W-1:0]        ins_idx;
  logic [IDX_W-1:0]        rem_idx;
  logic [IDX_W-1:0]        shift_idx;
  logic [IDX_W-1:0]        rd_idx;
  cell_cmd_t               cmd;
  logic [DATA_WIDTH-1:0]   new_val;
  logic [DATA_WIDTH-1:0]   cell_q [CAPACITY];
  logic signed [63:0]      rd_wide;
  logic signed [VAL_W-1:0] rd_value;
  logic [STATUS_W-1:0]     status_nxt;

  // A new request is taken whenever the output register is free or being emptied,
  // so a waiting result never blocks the transfer behind it for more than that stall.
  // No request is taken while reset is held.
  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign full         = (count_r == CAP_CNT);
  assign empty        = (count_r == '0);
  assign pos_x        = CMP_W'(in_ch.position);
  assign cnt_x        = CMP_W'(count_r);
  assign pos_past_end = (pos_x >= cnt_x);

  // A position at or past the count means the tail: the append slot for an insert,
  // the last element for a remove. Below the count the position fits the index width.
  assign ins_idx = pos_past_end ? IDX_W'(count_r) : IDX_W'(in_ch.position);
  assign rem_idx = pos_past_end ? IDX_W'(count_r - CNT_W'(1)) : IDX_W'(in_ch.position);
  assign rd_idx  = IDX_W'(in_ch.position);

  assign cmd.ins   = accept && (in_ch.req_type == REQ_INSERT) && !full;
  assign cmd.rem   = accept && (in_ch.req_type == REQ_REMOVE) && !empty;
  assign shift_idx = cmd.ins ? ins_idx : rem_idx;

  // Values are kept in their low DATA_WIDTH bits, taken from the unsigned input word.
  assign new_val = DATA_WIDTH'($unsigned(in_ch.item_value));

  // Chain of cells: each cell sees its two neighbors and the broadcast command.
  // The ends of the chain feed back their own contents where no neighbor exists.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val;
    logic [DATA_WIDTH-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = cell_q[g];
    end else begin : g_mid_l
      assign left_val = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = cell_q[g];
    end else begin : g_mid_r
      assign right_val = cell_q[g+1];
    end

    isu_cell #(
      .IDX_W (IDX_W),
      .DW    (DATA_WIDTH),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (shift_idx),
      .new_val   (new_val),
      .left_val  (left_val),
      .right_val (right_val),
      .data_q    (cell_q[g])
    );
  end

  // The read value is sign-extended from the stored width, then cut to the port width.
  assign rd_wide  = 64'($signed(cell_q[rd_idx]));
  assign rd_value = rd_wide[VAL_W-1:0];

  // Next count and status of the request on the input channel.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    case (in_ch.req_type)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_past_end) begin
          status_nxt = ST_RANGE;
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with every accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r <= ((in_ch.req_type == REQ_READ) && (status_nxt == ST_OK)) ?
                      rd_value : '0;
      total_r      <= TOTAL_W'(count_nxt);
      status_r     <= status_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_value    = read_value_r;
  assign out_ch.element_total = total_r;
  assign out_ch.status        = status_r;

  // The count never passes the capacity.
  `ISU_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CAP_CNT)
  // An insert into a full store is refused and leaves the count alone.
  `ISU_ASSERT_NEXT(a_full_refused, accept && (in_ch.req_type == REQ_INSERT) && full,
                   (status_r == ST_FULL) && (count_r == $past(count_r)))
  // An accepted insert with room grows the count by one.
  `ISU_ASSERT_NEXT(a_insert_grows, cmd.ins, count_r == $past(count_r) + CNT_W'(1))
  // A clear empties the store.
  `ISU_ASSERT_NEXT(a_clear_empties, accept && (in_ch.req_type == REQ_CLEAR),
                   (count_r == '0) && (status_r == ST_OK))
  // A nonzero read value only comes with a good status.
  `ISU_ASSERT_SAME(a_read_status, out_valid_r && (read_value_r != '0), status_r == ST_OK)

endmodule
